// ===== src/pthc_pkg.sv =====
package pthc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMP_CAL       = 3'd0;
  localparam logic [2:0] REG_PRESS_CAL_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_CAL_HIGH = 3'd2;
  localparam logic [2:0] REG_PRESS_CAL_LAST = 3'd3;
  localparam logic [2:0] REG_HUM_CAL_A      = 3'd4;
  localparam logic [2:0] REG_HUM_CAL_B      = 3'd5;

  // Width of the pressure division, one quotient bit per stage
  localparam int DIV_W = 64;

  // Upper humidity bound before the final shift
  localparam logic [31:0] HUM_MAX = 32'd419430400;

  // Finished temperature and humidity results, carried beside the division
  typedef struct packed {
    logic [16:0] hum;
    logic [31:0] tf;
    logic [31:0] tc;
  } pthc_res_t;

  // Operands of the pressure division
  typedef struct packed {
    logic [63:0] un;
    logic [63:0] ud;
    logic        neg;
    logic        zero;
  } pthc_div_in_t;

  // Result of the pressure division
  typedef struct packed {
    logic        valid;
    logic [63:0] quo;
    logic        neg;
    logic        zero;
  } pthc_div_out_t;

endpackage

// ===== src/pthc_div.sv =====
module pthc_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  pthc_pkg::pthc_div_in_t  din,
  input  pthc_pkg::pthc_res_t     res_in,
  output pthc_pkg::pthc_div_out_t dout,
  output pthc_pkg::pthc_res_t     res_out
);

  typedef struct packed {
    logic                valid;
    logic [62:0]         rem;
    logic [63:0]         dvd;
    logic [63:0]         ud;
    logic                neg;
    logic                zero;
    pthc_pkg::pthc_res_t res;
  } stage_t;

  stage_t pipe [0:pthc_pkg::DIV_W];

  always_comb begin
    pipe[0].valid = in_valid;
    pipe[0].rem   = '0;
    pipe[0].dvd   = din.un;
    pipe[0].ud    = din.ud;
    pipe[0].neg   = din.neg;
    pipe[0].zero  = din.zero;
    pipe[0].res   = res_in;
  end

  // One restoring step per stage: shift in a dividend bit, subtract if it fits
  for (genvar k = 0; k < pthc_pkg::DIV_W; k++) begin : g_step
    logic [63:0] part;
    logic [64:0] diff;
    stage_t      nxt;

    always_comb begin
      part = {pipe[k].rem, pipe[k].dvd[63]};
      diff = {1'b0, part} - {1'b0, pipe[k].ud};
      nxt       = pipe[k];
      nxt.rem   = diff[64] ? part[62:0] : diff[62:0];
      nxt.dvd   = {pipe[k].dvd[62:0], ~diff[64]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k+1].valid <= 1'b0;
      end else if (en) begin
        pipe[k+1] <= nxt;
      end
    end
  end

  assign dout.valid = pipe[pthc_pkg::DIV_W].valid;
  assign dout.quo   = pipe[pthc_pkg::DIV_W].dvd;
  assign dout.neg   = pipe[pthc_pkg::DIV_W].neg;
  assign dout.zero  = pipe[pthc_pkg::DIV_W].zero;
  assign res_out    = pipe[pthc_pkg::DIV_W].res;

endmodule

// ===== src/pth_sensor_compensation_unit.sv =====
// Pressure / temperature / humidity compensation pipeline.
// Input stream (s_tvalid, s_tready, s_tdata) carries one raw sample triple per
// transfer; output stream (m_tvalid, m_tready, m_tdata) carries the compensated
// temperature, fine temperature, pressure (Q24.8) and humidity (Q22.10).
// Calibration coefficients are loaded through cfg_we / cfg_index / cfg_data,
// one packed register per write; the user must do so only while no sample is in flight.
// The block does not enforce this. Throughput: one sample per clock unless the output stalls.
// Between the input transfer and the result being offered lie 14 front stages (temperature,
// humidity, pressure numerator and divisor), the 64-stage one-bit-per-stage signed division,
// 6 back stages of pressure correction and the output register.
// A stalled output register holds its result; the pipeline behind it keeps
// advancing while its last stage is empty, and freezes as a whole once a
// second result is ready, so nothing is lost or repeated.
// Reset (rst, synchronous) clears all calibration registers to zero and empties
// the pipeline; payload registers keep whatever they held.
module pth_sensor_compensation_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,   // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // temperature_centi[31:0], fine_temperature[63:32],
                                  // pressure_q24_8[95:64], humidity_q22_10[112:96], zero above
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  function automatic logic [31:0] asr32(input logic [31:0] x, input int s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int s);
    return $signed(x) >>> s;
  endfunction

  // Low 64 bits of a 64-bit value times a signed 16-bit coefficient
  function automatic logic [63:0] mul_s16(input logic [63:0] a, input logic [15:0] b);
    logic [79:0] pr;
    pr = {16'b0, a} * {64'b0, b};
    return pr[63:0] - (b[15] ? {a[47:0], 16'b0} : 64'd0);
  endfunction

  // Low 64 bits of a 64-bit value times an unsigned 16-bit coefficient
  function automatic logic [63:0] mul_u16(input logic [63:0] a, input logic [15:0] b);
    logic [79:0] pr;
    pr = {16'b0, a} * {64'b0, b};
    return pr[63:0];
  endfunction

  // Calibration registers
  logic [47:0] temp_cal;
  logic [63:0] press_cal_low;
  logic [63:0] press_cal_high;
  logic [15:0] press_cal_last;
  logic [31:0] hum_cal_a;
  logic [31:0] hum_cal_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal       <= '0;
      press_cal_low  <= '0;
      press_cal_high <= '0;
      press_cal_last <= '0;
      hum_cal_a      <= '0;
      hum_cal_b      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pthc_pkg::REG_TEMP_CAL:       temp_cal       <= cfg_data[47:0];
        pthc_pkg::REG_PRESS_CAL_LOW:  press_cal_low  <= cfg_data;
        pthc_pkg::REG_PRESS_CAL_HIGH: press_cal_high <= cfg_data;
        pthc_pkg::REG_PRESS_CAL_LAST: press_cal_last <= cfg_data[15:0];
        pthc_pkg::REG_HUM_CAL_A:      hum_cal_a      <= cfg_data[31:0];
        pthc_pkg::REG_HUM_CAL_B:      hum_cal_b      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Coefficient fields, extended to the working width where the formula needs it
  logic [15:0] t1;
  logic [31:0] t2x, t3x;
  logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1x, h2x, h3x, h5x, h6x;
  logic [11:0] h4;

  always_comb begin
    t1  = temp_cal[15:0];
    t2x = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3x = {{16{temp_cal[47]}}, temp_cal[47:32]};
    p1  = press_cal_low[15:0];
    p2  = press_cal_low[31:16];
    p3  = press_cal_low[47:32];
    p4  = press_cal_low[63:48];
    p5  = press_cal_high[15:0];
    p6  = press_cal_high[31:16];
    p7  = press_cal_high[47:32];
    p8  = press_cal_high[63:48];
    p9  = press_cal_last;
    h1x = {24'b0, hum_cal_a[7:0]};
    h2x = {{16{hum_cal_a[23]}}, hum_cal_a[23:8]};
    h3x = {24'b0, hum_cal_a[31:24]};
    h4  = hum_cal_b[11:0];
    h5x = {{20{hum_cal_b[23]}}, hum_cal_b[23:12]};
    h6x = {{24{hum_cal_b[31]}}, hum_cal_b[31:24]};
  end

  // Pressure division outputs
  pthc_pkg::pthc_div_out_t dout;
  pthc_pkg::pthc_res_t     div_res;

  // Pipeline control: freeze only when the output holds a result and another waits
  logic en;
  logic [14:1] fv;
  logic [6:1]  bv;

  assign en       = !m_tvalid || m_tready || !bv[6];
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
      bv <= '0;
    end else if (en) begin
      fv <= {fv[13:1], s_tvalid};
      bv <= {bv[5:1], dout.valid};
    end
  end

  // Input unpacking and first-stage operands
  logic [19:0] adc_p, adc_t;
  logic [15:0] adc_h;
  logic [31:0] ta_in, d_in;

  always_comb begin
    adc_p = s_tdata[19:0];
    adc_t = s_tdata[39:20];
    adc_h = s_tdata[55:40];
    ta_in = {15'b0, adc_t[19:3]} - {15'b0, t1, 1'b0};
    d_in  = {16'b0, adc_t[19:4]} - {16'b0, t1};
  end

  // Front stage registers
  logic [31:0] st1_ta, st1_dd;
  logic [19:0] st1_adcp, st2_adcp, st3_adcp, st4_adcp, st5_adcp, st6_adcp, st7_adcp;
  logic [15:0] st1_adch, st2_adch, st3_adch, st4_adch, st5_adch;
  logic [31:0] st2_a, st2_b;
  logic [31:0] st3_tf, st4_tf, st5_tf, st6_tf, st7_tf, st8_tf, st9_tf, st10_tf;
  logic [31:0] st11_tf, st12_tf, st13_tf;
  logic [31:0] st4_tcm, st4_hv;
  logic [32:0] st4_pv;
  logic [31:0] st5_tc, st6_tc, st7_tc, st8_tc, st9_tc, st10_tc, st11_tc, st12_tc, st13_tc;
  logic [63:0] st5_vv, st5_pa, st5_pb;
  logic [31:0] st5_hm, st5_m6, st5_m3;
  logic [63:0] st6_v2a, st6_v1a, st6_pa, st6_pb;
  logic [31:0] st6_x, st6_ya, st6_yb;
  logic [63:0] st7_v2, st7_v1s;
  logic [31:0] st7_y0, st7_x;
  logic [63:0] st8_v1m, st8_numa;
  logic [31:0] st8_y1a, st8_x;
  logic [63:0] st9_v1, st9_num;
  logic [31:0] st9_y1, st9_x;
  logic [31:0] st10_y, st10_x;
  pthc_pkg::pthc_div_in_t st10_dv, st11_dv, st12_dv, st13_dv, st14_dv;
  logic [31:0] st11_vx, st12_vx, st12_ss, st13_vx, st13_m;
  pthc_pkg::pthc_res_t st14_res;

  // Intermediate values between stages
  logic signed [32:0] pv_s;
  logic signed [65:0] vv_full;
  logic [63:0] pv64, pn, num_abs, den_abs;
  logic [31:0] s12, hw;
  logic [16:0] hum_q;

  always_comb begin
    pv_s    = $signed(st4_pv);
    vv_full = pv_s * pv_s;
    pv64    = {{31{st4_pv[32]}}, st4_pv};
    pn      = 64'd1048576 - {44'b0, st7_adcp};
    num_abs = st9_num[63] ? 64'd0 - st9_num : st9_num;
    den_abs = st9_v1[63] ? 64'd0 - st9_v1 : st9_v1;
    s12     = asr32(st11_vx, 15);
    hw      = st13_vx - asr32(st13_m, 4);
    if (hw[31]) begin
      hum_q = '0;
    end else if (hw > pthc_pkg::HUM_MAX) begin
      hum_q = pthc_pkg::HUM_MAX[28:12];
    end else begin
      hum_q = hw[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature products
      st1_ta   <= ta_in * t2x;
      st1_dd   <= d_in * d_in;
      st1_adcp <= adc_p;
      st1_adch <= adc_h;

      st2_a    <= asr32(st1_ta, 11);
      st2_b    <= asr32(st1_dd, 12) * t3x;
      st2_adcp <= st1_adcp;
      st2_adch <= st1_adch;

      // fine temperature
      st3_tf   <= st2_a + asr32(st2_b, 14);
      st3_adcp <= st2_adcp;
      st3_adch <= st2_adch;

      st4_tf   <= st3_tf;
      st4_tcm  <= st3_tf + {st3_tf[29:0], 2'b0} + 32'd128;
      st4_pv   <= {st3_tf[31], st3_tf} - 33'd128000;
      st4_hv   <= st3_tf - 32'd76800;
      st4_adcp <= st3_adcp;
      st4_adch <= st3_adch;

      // first products of the pressure and humidity chains
      st5_tf   <= st4_tf;
      st5_tc   <= asr32(st4_tcm, 8);
      st5_vv   <= vv_full[63:0];
      st5_pa   <= mul_s16(pv64, p5);
      st5_pb   <= mul_s16(pv64, p2);
      st5_hm   <= h5x * st4_hv;
      st5_m6   <= h6x * st4_hv;
      st5_m3   <= h3x * st4_hv;
      st5_adcp <= st4_adcp;
      st5_adch <= st4_adch;

      st6_tf   <= st5_tf;
      st6_tc   <= st5_tc;
      st6_v2a  <= mul_s16(st5_vv, p6);
      st6_v1a  <= mul_s16(st5_vv, p3);
      st6_pa   <= st5_pa;
      st6_pb   <= st5_pb;
      st6_x    <= asr32({2'b0, st5_adch, 14'b0} - {h4, 20'b0} - st5_hm + 32'd16384, 15);
      st6_ya   <= asr32(st5_m6, 10);
      st6_yb   <= asr32(st5_m3, 11) + 32'd32768;
      st6_adcp <= st5_adcp;

      st7_tf   <= st6_tf;
      st7_tc   <= st6_tc;
      st7_v2   <= st6_v2a + {st6_pa[46:0], 17'b0} + {{13{p4[15]}}, p4, 35'b0};
      st7_v1s  <= asr64(st6_v1a, 8) + {st6_pb[51:0], 12'b0} + 64'h0000_8000_0000_0000;
      st7_y0   <= st6_ya * st6_yb;
      st7_x    <= st6_x;
      st7_adcp <= st6_adcp;

      st8_tf   <= st7_tf;
      st8_tc   <= st7_tc;
      st8_v1m  <= mul_u16(st7_v1s, p1);
      st8_numa <= {pn[32:0], 31'b0} - st7_v2;
      st8_y1a  <= asr32(st7_y0, 10) + 32'd2097152;
      st8_x    <= st7_x;

      st9_tf   <= st8_tf;
      st9_tc   <= st8_tc;
      st9_v1   <= asr64(st8_v1m, 33);
      st9_num  <= mul_u16(st8_numa, 16'd3125);
      st9_y1   <= st8_y1a * h2x;
      st9_x    <= st8_x;

      // division operands as magnitudes and a result sign
      st10_tf      <= st9_tf;
      st10_tc      <= st9_tc;
      st10_dv.un   <= num_abs;
      st10_dv.ud   <= den_abs;
      st10_dv.neg  <= st9_num[63] ^ st9_v1[63];
      st10_dv.zero <= (st9_v1 == 64'd0);
      st10_y       <= asr32(st9_y1 + 32'd8192, 14);
      st10_x       <= st9_x;

      st11_tf <= st10_tf;
      st11_tc <= st10_tc;
      st11_dv <= st10_dv;
      st11_vx <= st10_x * st10_y;

      st12_tf <= st11_tf;
      st12_tc <= st11_tc;
      st12_dv <= st11_dv;
      st12_vx <= st11_vx;
      st12_ss <= s12 * s12;

      st13_tf <= st12_tf;
      st13_tc <= st12_tc;
      st13_dv <= st12_dv;
      st13_vx <= st12_vx;
      st13_m  <= asr32(st12_ss, 7) * h1x;

      // clamp humidity and drop the fraction below Q22.10
      st14_res.tc  <= st13_tc;
      st14_res.tf  <= st13_tf;
      st14_res.hum <= hum_q;
      st14_dv      <= st13_dv;
    end
  end

  // Pressure division
  pthc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (fv[14]),
    .din      (st14_dv),
    .res_in   (st14_res),
    .dout     (dout),
    .res_out  (div_res)
  );

  // Back stage registers
  pthc_pkg::pthc_res_t b1_res, b2_res, b3_res, b4_res, b5_res, b6_res;
  logic        b1_zero, b2_zero, b3_zero, b4_zero, b5_zero;
  logic [63:0] b1_p, b2_p, b3_p, b4_p;
  logic [63:0] b2_ll, b2_w2m, b3_sq, b3_w2, b4_w2, b4_w1m, b5_sum;
  logic [30:0] b2_hl;
  logic [31:0] b6_pres;
  logic [63:0] ps;
  logic [31:0] hl_full;

  always_comb begin
    ps      = asr64(b1_p, 13);
    hl_full = ps[63:32] * ps[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // apply the quotient sign
      b1_p    <= dout.neg ? 64'd0 - dout.quo : dout.quo;
      b1_zero <= dout.zero;
      b1_res  <= div_res;

      // square of the scaled pressure from 32-bit halves
      b2_p    <= b1_p;
      b2_ll   <= {32'b0, ps[31:0]} * {32'b0, ps[31:0]};
      b2_hl   <= hl_full[30:0];
      b2_w2m  <= mul_s16(b1_p, p8);
      b2_zero <= b1_zero;
      b2_res  <= b1_res;

      b3_p    <= b2_p;
      b3_sq   <= b2_ll + {b2_hl, 33'b0};
      b3_w2   <= asr64(b2_w2m, 19);
      b3_zero <= b2_zero;
      b3_res  <= b2_res;

      b4_p    <= b3_p;
      b4_w2   <= b3_w2;
      b4_w1m  <= mul_s16(b3_sq, p9);
      b4_zero <= b3_zero;
      b4_res  <= b3_res;

      b5_sum  <= b4_p + asr64(b4_w1m, 25) + b4_w2;
      b5_zero <= b4_zero;
      b5_res  <= b4_res;

      // zero divisor forces pressure to zero
      b6_pres <= b5_zero ? 32'd0 : b5_sum[39:8] + {{12{p7[15]}}, p7, 4'b0};
      b6_res  <= b5_res;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= bv[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= {7'b0, b6_res.hum, b6_pres, b6_res.tf, b6_res.tc};
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  // Raw sample triple as it travels on s_tdata
  typedef struct packed {
    logic [15:0] hum;
    logic [19:0] temp;
    logic [19:0] press;
  } raw_sample_t;

  // Compensated result as it travels on m_tdata
  typedef struct packed {
    logic [16:0] hum;
    logic [31:0] press;
    logic [31:0] tf;
    logic [31:0] tc;
  } comp_result_t;

  localparam int LATENCY  = 84;
  localparam int WATCHDOG = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  pth_sensor_compensation_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Calibration copy held by the predictor
  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo, cal_press_hi;
  logic [15:0] cal_press_last;
  logic [31:0] cal_hum_a, cal_hum_b;

  raw_sample_t  sample_queue[$];
  comp_result_t expected_results[$];
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           quiet_cycles = 0;

  // Compute one compensated result from a raw triple and the calibration copy
  function automatic comp_result_t compensate(raw_sample_t smp);
    comp_result_t r;
    logic signed [31:0] t1, t2, t3, a, d, b, tf, tc;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, pn, ps, w1, w2, un, ud, q;
    logic signed [31:0] h1, h2, h3, h4, h5, h6, hv, hx, hy, hs;
    logic signed [31:0] adc_t, adc_h;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    adc_t = {12'd0, smp.temp};
    adc_h = {16'd0, smp.hum};
    a  = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d  = (adc_t >>> 4) - t1;
    b  = (((d * d) >>> 12) * t3) >>> 14;
    tf = a + b;
    tc = (tf * 5 + 128) >>> 8;

    p1 = {48'd0, cal_press_lo[15:0]};
    p2 = {{48{cal_press_lo[31]}}, cal_press_lo[31:16]};
    p3 = {{48{cal_press_lo[47]}}, cal_press_lo[47:32]};
    p4 = {{48{cal_press_lo[63]}}, cal_press_lo[63:48]};
    p5 = {{48{cal_press_hi[15]}}, cal_press_hi[15:0]};
    p6 = {{48{cal_press_hi[31]}}, cal_press_hi[31:16]};
    p7 = {{48{cal_press_hi[47]}}, cal_press_hi[47:32]};
    p8 = {{48{cal_press_hi[63]}}, cal_press_hi[63:48]};
    p9 = {{48{cal_press_last[15]}}, cal_press_last};
    v1 = 64'(tf) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    r.press = '0;
    if (v1 != 0) begin
      pn = 64'sd1048576 - 64'($unsigned({44'd0, smp.press}));
      pn = ((pn <<< 31) - v2) * 64'sd3125;
      // truncate toward zero on magnitudes; the most negative value wraps
      un = pn[63] ? -pn : pn;
      ud = v1[63] ? -v1 : v1;
      q  = 64'($unsigned(un) / $unsigned(ud));
      pn = (pn[63] != v1[63]) ? -q : q;
      ps = pn >>> 13;
      w1 = (p9 * ps * ps) >>> 25;
      w2 = (p8 * pn) >>> 19;
      pn = ((pn + w1 + w2) >>> 8) + (p7 <<< 4);
      r.press = pn[31:0];
    end

    h1 = {24'd0, cal_hum_a[7:0]};
    h2 = {{16{cal_hum_a[23]}}, cal_hum_a[23:8]};
    h3 = {24'd0, cal_hum_a[31:24]};
    h4 = {{20{cal_hum_b[11]}}, cal_hum_b[11:0]};
    h5 = {{20{cal_hum_b[23]}}, cal_hum_b[23:12]};
    h6 = {{24{cal_hum_b[31]}}, cal_hum_b[31:24]};
    hv = tf - 32'sd76800;
    hx = ((adc_h <<< 14) - (h4 <<< 20) - h5 * hv + 32'sd16384) >>> 15;
    hy = ((hv * h6) >>> 10) * (((hv * h3) >>> 11) + 32'sd32768);
    hy = ((((hy >>> 10) + 32'sd2097152) * h2) + 32'sd8192) >>> 14;
    hv = hx * hy;
    hs = hv >>> 15;
    hv = hv - ((((hs * hs) >>> 7) * h1) >>> 4);
    // clamp before the final shift
    if (hv[31]) hv = 0;
    else if ($unsigned(hv) > pthc_pkg::HUM_MAX) hv = pthc_pkg::HUM_MAX;
    r.hum = hv[28:12];
    r.tc = tc;
    r.tf = tf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Driver: advance s_tvalid/s_tdata after each transfer, idling at random
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= sample_queue.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Prediction at each input transfer
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      expected_results.push_back(compensate(raw_sample_t'(s_tdata)));
  end

  // Monitor: compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    comp_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = comp_result_t'(m_tdata[112:0]);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.tc !== want.tc) report_mismatch("temperature", got.tc, want.tc);
        if (got.tf !== want.tf) report_mismatch("fine temp", got.tf, want.tf);
        if (got.press !== want.press) report_mismatch("pressure", got.press, want.press);
        if (got.hum !== want.hum) report_mismatch("humidity", 32'(got.hum), 32'(want.hum));
        if (m_tdata[119:113] !== '0) report_mismatch("padding", 32'(m_tdata[119:113]), 0);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mix of field extremes and random values, biased toward real readings
  function automatic raw_sample_t rand_sample();
    raw_sample_t smp;
    case ($urandom_range(3))
      0: smp = raw_sample_t'(56'({$urandom(), $urandom()}));
      1: smp = '{hum: 16'($urandom_range(20000, 40000)), temp: 20'($urandom_range(400000, 600000)),
                 press: 20'($urandom_range(250000, 450000))};
      2: smp = '{hum: ($urandom_range(1) ? 16'hFFFF : 16'h0),
                 temp: ($urandom_range(1) ? 20'hFFFFF : 20'h0),
                 press: 20'($urandom())};
      default: smp = '{hum: 16'($urandom()), temp: 20'($urandom()),
                       press: ($urandom_range(1) ? 20'hFFFFF : 20'h0)};
    endcase
    return smp;
  endfunction

  // Write one register while the pipeline is empty; mirror into the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      pthc_pkg::REG_TEMP_CAL:       cal_temp       = val[47:0];
      pthc_pkg::REG_PRESS_CAL_LOW:  cal_press_lo   = val;
      pthc_pkg::REG_PRESS_CAL_HIGH: cal_press_hi   = val;
      pthc_pkg::REG_PRESS_CAL_LAST: cal_press_last = val[15:0];
      pthc_pkg::REG_HUM_CAL_A:      cal_hum_a      = val[31:0];
      pthc_pkg::REG_HUM_CAL_B:      cal_hum_b      = val[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued sample has moved and every result has come back;
  // check at the falling edge, once the driver's updates have settled
  task automatic drain();
    @(negedge clk);
    while (sample_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Load a calibration set resembling a real part
  task automatic load_typical();
    write_reg(pthc_pkg::REG_TEMP_CAL, {16'($signed(-1000)), 16'd26435, 16'd27504});
    write_reg(pthc_pkg::REG_PRESS_CAL_LOW,
              {16'd2855, 16'($signed(-10685)), 16'd3024, 16'd36477});
    write_reg(pthc_pkg::REG_PRESS_CAL_HIGH,
              {16'($signed(-7)), 16'd15500, 16'($signed(-7)), 16'd140});
    write_reg(pthc_pkg::REG_PRESS_CAL_LAST, 16'd6000);
    write_reg(pthc_pkg::REG_HUM_CAL_A, {8'd0, 16'd362, 8'd75});
    write_reg(pthc_pkg::REG_HUM_CAL_B, {8'd30, 12'd50, 12'd313});
  endtask

  task automatic load_random();
    for (int i = 0; i < 6; i++) write_reg(3'(i), rand64());
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) sample_queue.push_back(rand_sample());
    drain();
  endtask

  initial begin
    cal_temp = '0; cal_press_lo = '0; cal_press_hi = '0;
    cal_press_last = '0; cal_hum_a = '0; cal_hum_b = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: all-zero calibration gives a zero divisor
    sample_queue.push_back('0);
    sample_queue.push_back('1);
    drain();

    // Indexes past the list must be ignored
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= 3'd6; cfg_data <= '1;
    @(posedge clk);
    cfg_index <= 3'd7;
    @(posedge clk);
    cfg_we <= 1'b0;

    load_typical();
    sample_queue.push_back('{hum: 16'd27000, temp: 20'd519888, press: 20'd415148});
    sample_queue.push_back('0);
    sample_queue.push_back('1);
    sample_queue.push_back('{hum: 16'hFFFF, temp: 20'h0, press: 20'hFFFFF});
    sample_queue.push_back('{hum: 16'h0, temp: 20'hFFFFF, press: 20'h0});
    sample_queue.push_back('{hum: 16'hAAAA, temp: 20'h55555, press: 20'hAAAAA});
    sample_queue.push_back('{hum: 16'h5555, temp: 20'hAAAAA, press: 20'h55555});
    drain();

    // Extreme calibration: all ones, then signs at their limits
    for (int i = 0; i < 6; i++) write_reg(3'(i), '1);
    for (int i = 0; i < 6; i++) sample_queue.push_back(rand_sample());
    drain();
    for (int i = 0; i < 6; i++) write_reg(3'(i), 64'h8000_8000_8000_8000);
    for (int i = 0; i < 6; i++) sample_queue.push_back(rand_sample());
    drain();

    // Sender idles 37 %, receiver 74 %
    send_idle_pct = 37; recv_idle_pct = 74;
    load_typical();
    run_random(250);
    load_random();
    run_random(250);

    // Roles swapped
    send_idle_pct = 74; recv_idle_pct = 37;
    load_typical();
    run_random(250);
    load_random();
    run_random(250);

    // No idling on either side
    send_idle_pct = 0; recv_idle_pct = 0;
    load_typical();
    run_random(300);
    load_random();
    run_random(250);

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pthc_pkg.sv
src/pthc_div.sv
src/pth_sensor_compensation_unit.sv
test/tb.sv
